### rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [CP_W-1:0]  REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0]  MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0]  MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0]  MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0]  MIN_LEN4    = 21'h010000;
    localparam logic [CP_W-1:0]  SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0]  SURR_HI     = 21'h00DFFF;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [LEN_W-1:0] err_cnt;
        logic             good;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] glen;
    } t_desc;

endpackage

### rtl/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Tracks the pending sequence and turns each byte that gives a result into a result descriptor.
// ----------------------------------------------------------------------------
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_final,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [LEN_W-1:0] r_exp, n_exp;
    logic [LEN_W-1:0] r_have, n_have;
    logic [CP_W-1:0]  r_acc, n_acc;

    logic             pending;
    logic             is_cont;
    logic [CP_W-1:0]  acc_next;
    logic [LEN_W-1:0] have_next;
    logic             val_ok;
    logic [LEN_W-1:0] lead_len;
    logic [CP_W-1:0]  lead_val;
    t_desc            desc;

    assign pending   = (r_exp != LEN_NONE);
    assign is_cont   = (i_byte[7:6] == 2'b10);
    assign acc_next  = {r_acc[CP_W-7:0], i_byte[5:0]};
    assign have_next = r_have + LEN_1;

    always_comb begin
        val_ok = 1'b1;
        if (r_exp == LEN_2 && acc_next < MIN_LEN2) val_ok = 1'b0;
        if (r_exp == LEN_3 && acc_next < MIN_LEN3) val_ok = 1'b0;
        if (r_exp == LEN_4 && acc_next < MIN_LEN4) val_ok = 1'b0;
        if (acc_next >= SURR_LO && acc_next <= SURR_HI) val_ok = 1'b0;
        if (acc_next > MAX_SCALAR) val_ok = 1'b0;
    end

    always_comb begin
        lead_len = LEN_NONE;
        lead_val = '0;
        if (i_byte[7:5] == 3'b110) begin
            lead_len = LEN_2;
            lead_val = {16'd0, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_len = LEN_3;
            lead_val = {17'd0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_len = LEN_4;
            lead_val = {18'd0, i_byte[2:0]};
        end
    end

    always_comb begin
        n_exp        = r_exp;
        n_have       = r_have;
        n_acc        = r_acc;
        desc.err_cnt = LEN_NONE;
        desc.good    = 1'b0;
        desc.cp      = acc_next;
        desc.glen    = r_exp;
        if (pending && is_cont) begin
            if (have_next >= r_exp) begin
                if (val_ok) begin
                    desc.good = 1'b1;
                end else begin
                    desc.err_cnt = r_exp;
                end
                n_exp  = LEN_NONE;
                n_have = LEN_NONE;
                n_acc  = '0;
            end else if (i_final) begin
                desc.err_cnt = have_next;
                n_exp  = LEN_NONE;
                n_have = LEN_NONE;
                n_acc  = '0;
            end else begin
                n_have = have_next;
                n_acc  = acc_next;
            end
        end else begin
            desc.err_cnt = pending ? r_have : LEN_NONE;
            n_exp  = LEN_NONE;
            n_have = LEN_NONE;
            n_acc  = '0;
            if (!i_byte[7]) begin
                desc.good = 1'b1;
                desc.cp   = {13'd0, i_byte};
                desc.glen = LEN_1;
            end else if (lead_len != LEN_NONE && !i_final) begin
                n_exp  = lead_len;
                n_have = LEN_1;
                n_acc  = lead_val;
            end else begin
                desc.err_cnt = desc.err_cnt + LEN_1;
            end
        end
    end

    assign o_push = i_take && (desc.good || desc.err_cnt != LEN_NONE);
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= LEN_NONE;
            r_have <= LEN_NONE;
            r_acc  <= '0;
        end else if (i_take) begin
            r_exp  <= n_exp;
            r_have <= n_have;
            r_acc  <= n_acc;
        end
    end

endmodule

### rtl/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short descriptor queue between the classifier and the result emitter.
// ----------------------------------------------------------------------------
module utf8d_queue
    import utf8d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nonempty,
    output t_desc o_head
);

    t_desc            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_cnt;

    assign o_full     = (r_cnt == QCW'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Expands descriptors into output-register words, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  t_desc            i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CP_W-1:0]  o_code_point,
    output logic             o_bad_seq,
    output logic [LEN_W-1:0] o_bytes_used,
    output logic             o_run_end
);

    logic [LEN_W-1:0] r_idx;
    logic             r_valid;
    logic [CP_W-1:0]  r_cp;
    logic             r_bad;
    logic [LEN_W-1:0] r_used;
    logic             r_end;

    logic             step;
    logic             is_err;
    logic             last;

    assign step   = i_head_valid && (!r_valid || i_out_ready);
    assign is_err = (r_idx < i_head.err_cnt);
    assign last   = is_err ? ((r_idx + LEN_1 == i_head.err_cnt) && !i_head.good) : 1'b1;
    assign o_pop  = step && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= LEN_NONE;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                r_idx   <= last ? LEN_NONE : r_idx + LEN_1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_cp   <= is_err ? REPLACEMENT : i_head.cp;
            r_bad  <= is_err;
            r_used <= is_err ? LEN_1 : i_head.glen;
            r_end  <= last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_code_point = r_cp;
    assign o_bad_seq    = r_bad;
    assign o_bytes_used = r_used;
    assign o_run_end    = r_end;

endmodule

### rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder with U+FFFD replacement of malformed sequences.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one stream byte per word with
// i_in_byte and i_final_byte; i_final_byte flushes any pending sequence.
// Output channel: o_out_valid / i_out_ready carry one result per word:
// o_code_point, o_bad_seq, o_bytes_used and o_run_end, which marks the last
// result caused by one input byte. Bytes that only extend a pending sequence
// give no result.
// A result passes from its byte through the descriptor queue into the output
// register. Throughput: one byte per cycle while the receiver is ready and each
// byte gives at most one result; a byte giving more than one result keeps the
// single output register busy for each of them, and the two-entry descriptor
// queue absorbs the difference before o_in_ready drops.
// Reset clears the pending sequence, the queue and the output register.
// A stalled receiver holds the output word; the queue then fills and input
// is held off.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_final_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CP_W-1:0]  o_code_point,
    output logic             o_bad_seq,
    output logic [LEN_W-1:0] o_bytes_used,
    output logic             o_run_end
);

    logic  take;
    logic  push;
    t_desc desc;
    logic  q_full;
    logic  q_nonempty;
    t_desc q_head;
    logic  pop;

    assign o_in_ready = !q_full;
    assign take       = i_in_valid && !q_full;

    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in_byte),
        .i_final (i_final_byte),
        .o_push  (push),
        .o_desc  (desc)
    );

    utf8d_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_desc     (desc),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    utf8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_nonempty),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_point (o_code_point),
        .o_bad_seq    (o_bad_seq),
        .o_bytes_used (o_bytes_used),
        .o_run_end    (o_run_end)
    );

endmodule

### rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module utf8d_checker
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [CP_W-1:0]  o_code_point,
    input  logic             o_bad_seq,
    input  logic [LEN_W-1:0] o_bytes_used,
    input  logic             o_run_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_point)
            && $stable(o_bad_seq) && $stable(o_run_end))
        else $error("output word changed while stalled");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_seq |-> o_code_point == REPLACEMENT && o_bytes_used == LEN_1)
        else $error("error result not a single-byte replacement");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_seq |-> o_bytes_used != LEN_NONE && o_bytes_used <= LEN_4
            && o_code_point <= MAX_SCALAR
            && (o_code_point < SURR_LO || o_code_point > SURR_HI))
        else $error("decoded value out of range");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_seq && o_bytes_used == LEN_1 |-> o_code_point < MIN_LEN2 && o_run_end)
        else $error("single-byte result not ASCII");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_stream_decoder utf8d_checker u_chk (.*);
